// ----- rtl/polyline_scale_and_window_clip_assert.svh -----
// Assertion macros used by the polyline_scale_and_window_clip RTL.
`ifndef POLYLINE_SCALE_AND_WINDOW_CLIP_ASSERT_SVH
`define POLYLINE_SCALE_AND_WINDOW_CLIP_ASSERT_SVH

// same-cycle implication
`define PSWC_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pswc assertion failed");

// next-cycle implication
`define PSWC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pswc assertion failed");

`endif

// ----- rtl/pswc_pkg.sv -----
package pswc_pkg;

   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 16;
   localparam int DIV_BITS   = 32;
   localparam int DVS_BITS   = 16;

   localparam logic [2:0] REG_X_SCALE  = 3'd0;
   localparam logic [2:0] REG_X_OFFSET = 3'd1;
   localparam logic [2:0] REG_Y_SCALE  = 3'd2;
   localparam logic [2:0] REG_Y_OFFSET = 3'd3;
   localparam logic [2:0] REG_WIN_L    = 3'd4;
   localparam logic [2:0] REG_WIN_R    = 3'd5;
   localparam logic [2:0] REG_WIN_B    = 3'd6;
   localparam logic [2:0] REG_WIN_T    = 3'd7;

   localparam logic [3:0] OC_LEFT   = 4'd1;
   localparam logic [3:0] OC_RIGHT  = 4'd2;
   localparam logic [3:0] OC_BOTTOM = 4'd4;
   localparam logic [3:0] OC_TOP    = 4'd8;

   localparam logic signed [COORD_BITS-1:0] COORD_MAX = 16'sh7FFF;
   localparam logic signed [COORD_BITS-1:0] COORD_MIN = 16'sh8000;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   function automatic coord_type scale_round(input logic signed [65:0] prod,
                                             input logic signed [31:0] ofs);
      logic signed [65:0] v;
      logic [65:0]        mag;
      logic [33:0]        m;
      v   = prod + (66'(ofs) <<< FRAC_BITS);
      mag = v[65] ? 66'(-v) : 66'(v);
      m   = 34'((mag + (66'd1 << (2*FRAC_BITS-1))) >> (2*FRAC_BITS));
      if (v[65]) begin
         if (m > 34'd32768) return COORD_MIN;
         return coord_type'(16'd0 - m[15:0]);
      end
      if (m > 34'd32767) return COORD_MAX;
      return coord_type'(m[15:0]);
   endfunction

   function automatic coord_type sat_coord(input logic signed [34:0] v);
      if (v > 35'sd32767) return COORD_MAX;
      if (v < -35'sd32768) return COORD_MIN;
      return coord_type'(v[15:0]);
   endfunction

   function automatic logic [3:0] outcode(input coord_type x, input coord_type y,
                                          input coord_type l, input coord_type r,
                                          input coord_type b, input coord_type t);
      logic [3:0] c;
      c = (x < l) ? OC_LEFT : ((x > r) ? OC_RIGHT : 4'd0);
      if (y < b) return c | OC_BOTTOM;
      if (y > t) return c | OC_TOP;
      return c;
   endfunction

endpackage

// ----- rtl/pswc_req_if.sv -----
interface pswc_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [31:0] x_coord;
   logic [31:0] y_coord;

   modport source (output valid, mode, x_coord, y_coord, input ready);
   modport sink (input valid, mode, x_coord, y_coord, output ready);
endinterface

// ----- rtl/pswc_rsp_if.sv -----
interface pswc_rsp_if;
   logic        valid;
   logic        ready;
   logic        pen_down;
   logic [15:0] out_x;
   logic [15:0] out_y;
   logic        last;

   modport source (output valid, pen_down, out_x, out_y, last, input ready);
   modport sink (input valid, pen_down, out_x, out_y, last, output ready);
endinterface

// ----- rtl/pswc_divider.sv -----
module pswc_divider (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [pswc_pkg::DIV_BITS-1:0]      dividend,
   input  logic [pswc_pkg::DVS_BITS-1:0]      divisor,
   output logic [pswc_pkg::DIV_BITS:0]        quotient,
   output pswc_pkg::div_stat_type             stat
);

   logic [pswc_pkg::DIV_BITS-1:0] quo_ff, quo_in;
   logic [pswc_pkg::DVS_BITS-1:0] rem_ff, rem_in;
   logic [pswc_pkg::DVS_BITS-1:0] dvs_ff, dvs_in;
   logic [5:0]                    count_ff, count_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [pswc_pkg::DVS_BITS:0]   rem_s;
   logic                          ge;

   always_comb begin
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      rem_s    = {rem_ff, quo_ff[pswc_pkg::DIV_BITS-1]};
      ge       = rem_s >= {1'b0, dvs_ff};
      if (start) begin
         quo_in   = dividend;
         rem_in   = '0;
         dvs_in   = divisor;
         count_in = 6'(pswc_pkg::DIV_BITS);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = ge ? 16'(rem_s - {1'b0, dvs_ff}) : rem_s[pswc_pkg::DVS_BITS-1:0];
         quo_in   = {quo_ff[pswc_pkg::DIV_BITS-2:0], ge};
         count_in = count_ff - 6'd1;
         if (count_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   // round to nearest, ties away from zero
   assign quotient = {1'b0, quo_ff} +
                     33'({rem_ff, 1'b0} >= {1'b0, dvs_ff});
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// ----- rtl/polyline_scale_and_window_clip.sv -----
// Steps: a start item passes through states MULX, SCX, MULY and SCY; a
// continue item adds CODE, CHECK and, for each of up to four clip passes,
// MULC, DIVS, DIVW (nonzero divisor only) and APPLY, then OUT0 and/or OUT1.
// The 32-step serial divider dominates. One item is taken at a time, in IDLE.
// Reset (synchronous, active high): registers to defaults, pen lifted,
// previous vertex (0,0), no beat pending.
`include "polyline_scale_and_window_clip_assert.svh"

module polyline_scale_and_window_clip (
   input  logic        clock,
   input  logic        reset,
   pswc_req_if.sink    req_chan,
   pswc_rsp_if.source  rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   typedef enum logic [3:0] {
      S_IDLE, S_MULX, S_SCX, S_MULY, S_SCY, S_CODE, S_CHECK,
      S_MULC, S_DIVS, S_DIVW, S_APPLY, S_OUT0, S_OUT1
   } state_type;

   typedef logic signed [16:0] diff_type;

   state_type state_ff, state_in;

   logic signed [31:0] x_scale_ff, x_offset_ff, y_scale_ff, y_offset_ff;
   pswc_pkg::coord_type win_l_ff, win_r_ff, win_b_ff, win_t_ff;

   logic               mode_ff, mode_in;
   logic signed [31:0] xc_ff, xc_in, yc_ff, yc_in;
   logic signed [65:0] prod_ff, prod_in;
   pswc_pkg::coord_type x0_ff, x0_in, y0_ff, y0_in, x1_ff, x1_in, y1_ff, y1_in;
   pswc_pkg::coord_type prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   pswc_pkg::coord_type base_ff, base_in, fix_ff, fix_in;
   logic               pen_lifted_ff, pen_lifted_in;
   logic [3:0]         c0_ff, c0_in, c1_ff, c1_in, start_code_ff, start_code_in;
   logic [2:0]         pass_ff, pass_in;
   diff_type           a_ff, a_in, b_ff, b_in, d_ff, d_in;
   logic               vert_ff, vert_in, sel0_ff, sel0_in;
   logic               neg_ff, neg_in, dz_ff, dz_in;
   logic               rsp_valid_ff, rsp_valid_in, pen_down_ff, pen_down_in;
   logic               last_ff, last_in;
   pswc_pkg::coord_type out_x_ff, out_x_in, out_y_ff, out_y_in;

   logic signed [32:0] mul_a, mul_b;
   logic [3:0]         cc;
   logic [31:0]        div_dvd;
   logic [15:0]        div_dvs;
   logic [32:0]        div_q;
   logic               div_start;
   pswc_pkg::div_stat_type div_stat;
   logic signed [34:0] qs, sum;
   pswc_pkg::coord_type newv, sx, sy;
   logic [3:0]         ncode;
   logic               csr_wr;

   pswc_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .quotient (div_q),
      .stat     (div_stat)
   );

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      case (csr_paddr[4:2])
         pswc_pkg::REG_X_SCALE:  csr_prdata = x_scale_ff;
         pswc_pkg::REG_X_OFFSET: csr_prdata = x_offset_ff;
         pswc_pkg::REG_Y_SCALE:  csr_prdata = y_scale_ff;
         pswc_pkg::REG_Y_OFFSET: csr_prdata = y_offset_ff;
         pswc_pkg::REG_WIN_L:    csr_prdata = 32'(win_l_ff);
         pswc_pkg::REG_WIN_R:    csr_prdata = 32'(win_r_ff);
         pswc_pkg::REG_WIN_B:    csr_prdata = 32'(win_b_ff);
         pswc_pkg::REG_WIN_T:    csr_prdata = 32'(win_t_ff);
         default:                csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_scale_ff  <= 32'sd65536;
         x_offset_ff <= '0;
         y_scale_ff  <= 32'sd65536;
         y_offset_ff <= '0;
         win_l_ff    <= pswc_pkg::COORD_MIN;
         win_r_ff    <= pswc_pkg::COORD_MAX;
         win_b_ff    <= pswc_pkg::COORD_MIN;
         win_t_ff    <= pswc_pkg::COORD_MAX;
      end else if (csr_wr) begin
         case (csr_paddr[4:2])
            pswc_pkg::REG_X_SCALE:  x_scale_ff  <= csr_pwdata;
            pswc_pkg::REG_X_OFFSET: x_offset_ff <= csr_pwdata;
            pswc_pkg::REG_Y_SCALE:  y_scale_ff  <= csr_pwdata;
            pswc_pkg::REG_Y_OFFSET: y_offset_ff <= csr_pwdata;
            pswc_pkg::REG_WIN_L:    win_l_ff    <= csr_pwdata[15:0];
            pswc_pkg::REG_WIN_R:    win_r_ff    <= csr_pwdata[15:0];
            pswc_pkg::REG_WIN_B:    win_b_ff    <= csr_pwdata[15:0];
            pswc_pkg::REG_WIN_T:    win_t_ff    <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // shared multiplier operands
   always_comb begin
      case (state_ff)
         S_MULX: begin
            mul_a = 33'(xc_ff);
            mul_b = 33'(x_scale_ff);
         end
         S_MULY: begin
            mul_a = 33'(yc_ff);
            mul_b = 33'(y_scale_ff);
         end
         default: begin
            mul_a = 33'(a_ff);
            mul_b = 33'(b_ff);
         end
      endcase
   end

   assign req_chan.ready = (state_ff == S_IDLE);
   assign div_start = (state_ff == S_DIVS) && (d_ff != '0);
   assign div_dvd   = prod_ff[65] ? 32'(-prod_ff) : prod_ff[31:0];
   assign div_dvs   = d_ff[16] ? 16'(-d_ff) : d_ff[15:0];
   assign cc        = (c0_ff != 4'd0) ? c0_ff : c1_ff;
   assign qs        = dz_ff ? 35'sd0 :
                      (neg_ff ? -35'(signed'({2'b00, div_q})) : 35'(signed'({2'b00, div_q})));
   assign sum       = 35'(base_ff) + qs;
   assign newv      = pswc_pkg::sat_coord(sum);
   assign sx        = vert_ff ? fix_ff : newv;
   assign sy        = vert_ff ? newv : fix_ff;
   assign ncode     = pswc_pkg::outcode(sx, sy, win_l_ff, win_r_ff, win_b_ff, win_t_ff);

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      xc_in         = xc_ff;
      yc_in         = yc_ff;
      prod_in       = prod_ff;
      x0_in         = x0_ff;
      y0_in         = y0_ff;
      x1_in         = x1_ff;
      y1_in         = y1_ff;
      prev_x_in     = prev_x_ff;
      prev_y_in     = prev_y_ff;
      base_in       = base_ff;
      fix_in        = fix_ff;
      pen_lifted_in = pen_lifted_ff;
      c0_in         = c0_ff;
      c1_in         = c1_ff;
      start_code_in = start_code_ff;
      pass_in       = pass_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      d_in          = d_ff;
      vert_in       = vert_ff;
      sel0_in       = sel0_ff;
      neg_in        = neg_ff;
      dz_in         = dz_ff;
      rsp_valid_in  = rsp_valid_ff;
      pen_down_in   = pen_down_ff;
      last_in       = last_ff;
      out_x_in      = out_x_ff;
      out_y_in      = out_y_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               mode_in  = req_chan.mode;
               xc_in    = req_chan.x_coord;
               yc_in    = req_chan.y_coord;
               state_in = S_MULX;
            end
         end
         S_MULX: begin
            prod_in  = mul_a * mul_b;
            state_in = S_SCX;
         end
         S_SCX: begin
            x1_in    = pswc_pkg::scale_round(prod_ff, x_offset_ff);
            state_in = S_MULY;
         end
         S_MULY: begin
            prod_in  = mul_a * mul_b;
            state_in = S_SCY;
         end
         S_SCY: begin
            y1_in     = pswc_pkg::scale_round(prod_ff, y_offset_ff);
            x0_in     = prev_x_ff;
            y0_in     = prev_y_ff;
            prev_x_in = x1_ff;
            prev_y_in = y1_in;
            if (!mode_ff) begin
               pen_lifted_in = 1'b1;
               state_in      = S_IDLE;
            end else begin
               state_in = S_CODE;
            end
         end
         S_CODE: begin
            c0_in = pswc_pkg::outcode(x0_ff, y0_ff, win_l_ff, win_r_ff, win_b_ff, win_t_ff);
            c1_in = pswc_pkg::outcode(x1_ff, y1_ff, win_l_ff, win_r_ff, win_b_ff, win_t_ff);
            start_code_in = c0_in;
            pass_in       = '0;
            state_in      = S_CHECK;
         end
         S_CHECK: begin
            if (pass_ff < 3'd4 && (c0_ff | c1_ff) != 4'd0 && (c0_ff & c1_ff) == 4'd0) begin
               sel0_in = (c0_ff != 4'd0);
               if ((cc & pswc_pkg::OC_LEFT) != 4'd0 || (cc & pswc_pkg::OC_RIGHT) != 4'd0) begin
                  fix_in  = ((cc & pswc_pkg::OC_LEFT) != 4'd0) ? win_l_ff : win_r_ff;
                  vert_in = 1'b1;
                  base_in = y0_ff;
                  a_in    = diff_type'(y1_ff) - diff_type'(y0_ff);
                  b_in    = diff_type'(fix_in) - diff_type'(x0_ff);
                  d_in    = diff_type'(x1_ff) - diff_type'(x0_ff);
               end else begin
                  fix_in  = ((cc & pswc_pkg::OC_BOTTOM) != 4'd0) ? win_b_ff : win_t_ff;
                  vert_in = 1'b0;
                  base_in = x0_ff;
                  a_in    = diff_type'(x1_ff) - diff_type'(x0_ff);
                  b_in    = diff_type'(fix_in) - diff_type'(y0_ff);
                  d_in    = diff_type'(y1_ff) - diff_type'(y0_ff);
               end
               state_in = S_MULC;
            end else if ((c0_ff | c1_ff) != 4'd0) begin
               pen_lifted_in = 1'b1;
               state_in      = S_IDLE;
            end else if (pen_lifted_ff || start_code_ff != 4'd0) begin
               rsp_valid_in = 1'b1;
               pen_down_in  = 1'b0;
               last_in      = 1'b0;
               out_x_in     = x0_ff;
               out_y_in     = y0_ff;
               state_in     = S_OUT0;
            end else begin
               rsp_valid_in = 1'b1;
               pen_down_in  = 1'b1;
               last_in      = 1'b1;
               out_x_in     = x1_ff;
               out_y_in     = y1_ff;
               state_in     = S_OUT1;
            end
         end
         S_MULC: begin
            prod_in  = mul_a * mul_b;
            state_in = S_DIVS;
         end
         S_DIVS: begin
            neg_in   = prod_ff[65] ^ d_ff[16];
            dz_in    = (d_ff == '0);
            state_in = dz_in ? S_APPLY : S_DIVW;
         end
         S_DIVW: begin
            if (div_stat.done) state_in = S_APPLY;
         end
         S_APPLY: begin
            if (sel0_ff) begin
               x0_in = sx;
               y0_in = sy;
               c0_in = ncode;
            end else begin
               x1_in = sx;
               y1_in = sy;
               c1_in = ncode;
            end
            pass_in  = pass_ff + 3'd1;
            state_in = S_CHECK;
         end
         S_OUT0: begin
            if (rsp_chan.ready) begin
               pen_down_in = 1'b1;
               last_in     = 1'b1;
               out_x_in    = x1_ff;
               out_y_in    = y1_ff;
               state_in    = S_OUT1;
            end
         end
         S_OUT1: begin
            if (rsp_chan.ready) begin
               rsp_valid_in  = 1'b0;
               pen_lifted_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pen_lifted_ff <= 1'b1;
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
         pass_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         pen_lifted_ff <= pen_lifted_in;
         prev_x_ff     <= prev_x_in;
         prev_y_ff     <= prev_y_in;
         rsp_valid_ff  <= rsp_valid_in;
         pass_ff       <= pass_in;
      end
      mode_ff       <= mode_in;
      xc_ff         <= xc_in;
      yc_ff         <= yc_in;
      prod_ff       <= prod_in;
      x0_ff         <= x0_in;
      y0_ff         <= y0_in;
      x1_ff         <= x1_in;
      y1_ff         <= y1_in;
      base_ff       <= base_in;
      fix_ff        <= fix_in;
      c0_ff         <= c0_in;
      c1_ff         <= c1_in;
      start_code_ff <= start_code_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      d_ff          <= d_in;
      vert_ff       <= vert_in;
      sel0_ff       <= sel0_in;
      neg_ff        <= neg_in;
      dz_ff         <= dz_in;
      pen_down_ff   <= pen_down_in;
      last_ff       <= last_in;
      out_x_ff      <= out_x_in;
      out_y_ff      <= out_y_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.pen_down = pen_down_ff;
   assign rsp_chan.out_x    = out_x_ff;
   assign rsp_chan.out_y    = out_y_ff;
   assign rsp_chan.last     = last_ff;

   `PSWC_ASSERT_IMP(a_idle_no_beat, req_chan.ready, !rsp_chan.valid)
   `PSWC_ASSERT_NEXT(a_last_then_idle, rsp_chan.valid && rsp_chan.ready && rsp_chan.last, req_chan.ready)
   `PSWC_ASSERT_IMP(a_pass_bound, 1'b1, pass_ff <= 3'd4)
   `PSWC_ASSERT_IMP(a_div_owned, div_stat.busy, state_ff == S_DIVW)

endmodule

// ----- sim/polyline_scale_and_window_clip_tb.sv -----
`timescale 1ns / 100ps

module polyline_scale_and_window_clip_tb;

   localparam int LIMIT_CYCLES = 1000000;
   localparam int DRAIN_CYCLES = 200;

   typedef struct {
      logic                pen_down;
      pswc_pkg::coord_type out_x;
      pswc_pkg::coord_type out_y;
      logic                last;
   } vector_beat_type;

   class vector_scoreboard;
      longint          xs, xo, ys, yo, wl, wr, wb, wt;
      bit              lifted;
      longint          px, py;
      vector_beat_type pending[$];
      int              mismatches;
      int              beats_seen;
      int              segments;

      function new();
         xs = 65536; xo = 0; ys = 65536; yo = 0;
         wl = -32768; wr = 32767; wb = -32768; wt = 32767;
         lifted = 1; px = 0; py = 0;
         mismatches = 0; beats_seen = 0; segments = 0;
      endfunction

      function void set_reg(logic [2:0] idx, logic [31:0] val);
         case (idx)
            pswc_pkg::REG_X_SCALE:  xs = longint'($signed(val));
            pswc_pkg::REG_X_OFFSET: xo = longint'($signed(val));
            pswc_pkg::REG_Y_SCALE:  ys = longint'($signed(val));
            pswc_pkg::REG_Y_OFFSET: yo = longint'($signed(val));
            pswc_pkg::REG_WIN_L:    wl = longint'($signed(val[15:0]));
            pswc_pkg::REG_WIN_R:    wr = longint'($signed(val[15:0]));
            pswc_pkg::REG_WIN_B:    wb = longint'($signed(val[15:0]));
            pswc_pkg::REG_WIN_T:    wt = longint'($signed(val[15:0]));
            default: ;
         endcase
      endfunction

      function longint clamp16(longint v);
         if (v > 32767) return 32767;
         if (v < -32768) return -32768;
         return v;
      endfunction

      function longint to_device(longint c, longint s, longint o);
         longint v, m;
         v = c * s + (o <<< 16);
         m = (v < 0) ? -v : v;
         m = (m + (64'sd1 <<< 31)) >>> 32;
         if (m > (64'sd1 <<< 40)) m = 64'sd1 <<< 40;
         return clamp16((v < 0) ? -m : m);
      endfunction

      function longint cross_ofs(longint a, longint b, longint d);
         longint n, un, ud, q, r;
         bit neg;
         if (d == 0) return 0;
         neg = ((a < 0) != (b < 0)) != (d < 0);
         n = a * b;
         un = (n < 0) ? -n : n;
         ud = (d < 0) ? -d : d;
         q = un / ud;
         r = un % ud;
         if (r >= ud - r) q++;
         if (q > (64'sd1 <<< 40)) q = 64'sd1 <<< 40;
         return neg ? -q : q;
      endfunction

      function logic [3:0] region(longint x, longint y);
         logic [3:0] c;
         c = (x < wl) ? pswc_pkg::OC_LEFT : ((x > wr) ? pswc_pkg::OC_RIGHT : 4'd0);
         if (y < wb) return c | pswc_pkg::OC_BOTTOM;
         if (y > wt) return c | pswc_pkg::OC_TOP;
         return c;
      endfunction

      function void push_beat(bit down, longint x, longint y, bit lst);
         vector_beat_type b;
         b.pen_down = down;
         b.out_x = pswc_pkg::coord_type'(x);
         b.out_y = pswc_pkg::coord_type'(y);
         b.last = lst;
         pending.push_back(b);
      endfunction

      function void note_vertex(logic mode, logic [31:0] xc, logic [31:0] yc);
         longint cx, cy, x0, y0, x1, y1, x, y;
         logic [3:0] c0, c1, c, sc;
         cx = to_device(longint'($signed(xc)), xs, xo);
         cy = to_device(longint'($signed(yc)), ys, yo);
         x0 = px; y0 = py; x1 = cx; y1 = cy;
         px = cx; py = cy;
         if (!mode) begin
            lifted = 1;
            return;
         end
         c0 = region(x0, y0);
         sc = c0;
         c1 = region(x1, y1);
         for (int p = 0; p < 4 && (c0 | c1) != 0 && (c0 & c1) == 0; p++) begin
            c = (c0 != 0) ? c0 : c1;
            if (c & pswc_pkg::OC_LEFT) begin
               x = wl;
               y = y0 + cross_ofs(y1 - y0, wl - x0, x1 - x0);
            end else if (c & pswc_pkg::OC_RIGHT) begin
               x = wr;
               y = y0 + cross_ofs(y1 - y0, wr - x0, x1 - x0);
            end else if (c & pswc_pkg::OC_BOTTOM) begin
               y = wb;
               x = x0 + cross_ofs(x1 - x0, wb - y0, y1 - y0);
            end else begin
               y = wt;
               x = x0 + cross_ofs(x1 - x0, wt - y0, y1 - y0);
            end
            x = clamp16(x);
            y = clamp16(y);
            if (c == c0) begin
               x0 = x; y0 = y; c0 = region(x, y);
            end else begin
               x1 = x; y1 = y; c1 = region(x, y);
            end
         end
         if ((c0 | c1) != 0) begin
            lifted = 1;
            return;
         end
         if (lifted || sc != 0) push_beat(0, x0, y0, 0);
         push_beat(1, x1, y1, 1);
         lifted = 0;
         segments++;
      endfunction

      function void fail(string what, vector_beat_type e, vector_beat_type a);
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch (%s): expected pen=%0d x=%0d y=%0d last=%0d, %s",
                     what, e.pen_down, e.out_x, e.out_y, e.last,
                     $sformatf("got pen=%0d x=%0d y=%0d last=%0d",
                               a.pen_down, a.out_x, a.out_y, a.last));
      endfunction

      function void check_beat(vector_beat_type a);
         vector_beat_type e;
         beats_seen++;
         if (pending.size() == 0) begin
            e = '{default: 'x};
            fail("unexpected beat", e, a);
            return;
         end
         e = pending.pop_front();
         if (a.pen_down !== e.pen_down || a.out_x !== e.out_x ||
             a.out_y !== e.out_y || a.last !== e.last)
            fail("field", e, a);
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [4:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   pswc_req_if req_bus();
   pswc_rsp_if rsp_bus();

   polyline_scale_and_window_clip uut (
      .clock(clock), .reset(reset),
      .req_chan(req_bus.sink), .rsp_chan(rsp_bus.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   vector_scoreboard sb = new();
   bit no_idle = 0;
   bit hold_ask = 0;
   int cycles = 0;
   int vertices = 0;

   initial begin
      req_bus.valid = 0;
      req_bus.mode = 0;
      req_bus.x_coord = '0;
      req_bus.y_coord = '0;
      rsp_bus.ready = 0;
   end

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // result side: random back-pressure plus one long hold-off
   int hold_left = 0;
   always @(posedge clock) begin
      vector_beat_type a;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         a.pen_down = rsp_bus.pen_down;
         a.out_x = pswc_pkg::coord_type'(rsp_bus.out_x);
         a.out_y = pswc_pkg::coord_type'(rsp_bus.out_y);
         a.last = rsp_bus.last;
         sb.check_beat(a);
      end
      if (hold_ask && hold_left == 0) begin
         hold_ask <= 0;
         hold_left <= 400;
         rsp_bus.ready <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_bus.ready <= 0;
      end else
         rsp_bus.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 17);
   end

   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_penable <= 0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      sb.set_reg(idx, val);
   endtask

   task automatic send_vertex(logic mode, logic [31:0] xc, logic [31:0] yc);
      if (!no_idle)
         while ($urandom_range(99) < 17) begin
            req_bus.valid <= 0;
            @(posedge clock);
         end
      req_bus.valid <= 1;
      req_bus.mode <= mode;
      req_bus.x_coord <= xc;
      req_bus.y_coord <= yc;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_vertex(mode, xc, yc);
      vertices++;
   endtask

   task automatic settle();
      req_bus.valid <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_frame(logic [31:0] xsc, logic [31:0] xof, logic [31:0] ysc,
                            logic [31:0] yof, int l, int r, int b, int t);
      csr_write(pswc_pkg::REG_X_SCALE, xsc);
      csr_write(pswc_pkg::REG_X_OFFSET, xof);
      csr_write(pswc_pkg::REG_Y_SCALE, ysc);
      csr_write(pswc_pkg::REG_Y_OFFSET, yof);
      csr_write(pswc_pkg::REG_WIN_L, 32'(l));
      csr_write(pswc_pkg::REG_WIN_R, 32'(r));
      csr_write(pswc_pkg::REG_WIN_B, 32'(b));
      csr_write(pswc_pkg::REG_WIN_T, 32'(t));
   endtask

   function automatic logic [31:0] dev(int d);
      return 32'(d) << 16;
   endfunction

   function automatic logic [31:0] rand_coord();
      int k;
      k = $urandom_range(99);
      if (k < 70) return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
      if (k < 80) return 32'($signed($urandom_range(0, 32'h4000)) - 32'sh2000);
      if (k < 92) return $urandom();
      case ($urandom_range(3))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         default: return 32'hffff_ffff;
      endcase
   endfunction

   task automatic random_run(int count);
      int n;
      n = 0;
      while (n < count) begin
         if ($urandom_range(9) == 0) begin
            send_vertex(1'($urandom_range(1)), $urandom(), $urandom());
            n++;
         end else begin
            send_vertex(0, rand_coord(), rand_coord());
            n++;
            repeat ($urandom_range(2, 8)) begin
               send_vertex(1, rand_coord(), rand_coord());
               n++;
            end
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reset defaults: continue straight after reset, then coordinate extremes
      send_vertex(1, dev(5), dev(-7));
      send_vertex(1, 32'h7fff_ffff, 32'h8000_0000);
      send_vertex(1, 32'h8000_0000, 32'h7fff_ffff);
      send_vertex(0, 32'h0000_8000, 32'hffff_8000);
      send_vertex(1, 32'hffff_7fff, 32'h0000_7fff);
      settle();

      set_frame(32'h0001_0000, 0, 32'h0001_0000, 0, -100, 100, -100, 100);
      send_vertex(0, dev(-50), dev(-50));
      send_vertex(1, dev(50), dev(50));
      send_vertex(1, dev(60), dev(-20));
      send_vertex(1, dev(300), dev(20));
      send_vertex(1, dev(400), dev(90));
      send_vertex(1, dev(-300), dev(0));
      send_vertex(1, dev(0), dev(-300));
      send_vertex(1, dev(0), dev(300));
      send_vertex(1, dev(-250), dev(-40));
      send_vertex(1, dev(250), dev(260));
      send_vertex(1, dev(-300), dev(-300));
      send_vertex(1, dev(-200), dev(-250));
      send_vertex(1, dev(100), dev(-100));
      send_vertex(1, dev(-100), dev(100));
      settle();

      // inverted window: vertical segment through both y bounds
      set_frame(32'h0001_0000, 0, 32'h0001_0000, 0, 50, -50, 40, -40);
      send_vertex(0, dev(0), dev(-200));
      send_vertex(1, dev(0), dev(200));
      send_vertex(1, dev(70), dev(0));
      send_vertex(1, dev(-70), dev(60));
      settle();

      set_frame(32'h0001_0000, 0, 32'h0001_0000, 0, -200, 200, -150, 150);
      hold_ask <= 1;
      random_run(180);
      settle();

      no_idle = 1;
      set_frame(32'hffff_0000, 32'h0000_2000, 32'h0000_8000, 32'hffff_e000,
                -120, 240, -300, 60);
      random_run(180);
      settle();
      no_idle = 0;

      set_frame(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                -32768, 32767, 32767, -32768);
      random_run(150);
      settle();

      set_frame(32'h0000_0001, 32'h8000_0000, 32'h0003_0000, 32'h7fff_ffff,
                32767, 32767, -32768, -32768);
      random_run(120);
      settle();

      set_frame($urandom(), $urandom(), $urandom(), $urandom(),
                $signed(16'($urandom())), $signed(16'($urandom())),
                $signed(16'($urandom())), $signed(16'($urandom())));
      random_run(100);
      settle();

      set_frame(32'h0001_8000, 32'(-70) << 16, 32'h0000_c000, 32'(35) << 16,
                -400, 400, -300, 300);
      random_run(400);
      settle();

      if (sb.pending.size() != 0) sb.mismatches++;
      $display("Covered %0d vertices over nine register settings:", vertices);
      $display("%0d beats checked, %0d segments drawn.", sb.beats_seen, sb.segments);
      if (sb.mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/pswc_pkg.sv
rtl/pswc_req_if.sv
rtl/pswc_rsp_if.sv
rtl/pswc_divider.sv
rtl/polyline_scale_and_window_clip.sv
sim/polyline_scale_and_window_clip_tb.sv
